// ===== hw/rtl/gsp_pkg.sv =====
package gsp_pkg;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RS_MUL,
    ST_RS_LD,
    ST_DIV,
    ST_DIV_END,
    ST_NORM,
    ST_SQ_MUL,
    ST_SQ_UPD,
    ST_L10_MUL,
    ST_L10,
    ST_T_MUL,
    ST_T,
    ST_TRY,
    ST_DONE
  } state_t;

  // which quotient the shared divider is producing
  typedef enum logic [1:0] {
    PH_RS,
    PH_RO,
    PH_RAT,
    PH_X
  } phase_t;

  localparam logic [2:0] STAT_OK      = 3'd0;
  localparam logic [2:0] STAT_ZERO    = 3'd1;
  localparam logic [2:0] STAT_NOCAL   = 3'd2;
  localparam logic [2:0] STAT_SAT     = 3'd3;
  localparam logic [2:0] STAT_UNSEL   = 3'd4;

  localparam int CFG_AW = 3;
  localparam logic [CFG_AW-1:0] REG_LOAD_RES  = 3'd0;
  localparam logic [CFG_AW-1:0] REG_CAF       = 3'd1;
  localparam logic [CFG_AW-1:0] REG_X0        = 3'd2;
  localparam logic [CFG_AW-1:0] REG_Y0        = 3'd3;
  localparam logic [CFG_AW-1:0] REG_SLOPE     = 3'd4;
  localparam logic [CFG_AW-1:0] REG_GAS_SEL   = 3'd5;

  localparam logic [32:0] LOG10_2_Q16 = 33'd19728;
  localparam logic [32:0] LOG2_10_Q16 = 33'd217706;

  localparam int DIV_STEPS = 48;
  localparam int SQ_STEPS  = 16;

endpackage

// ===== hw/rtl/gas_sensor_ppm_converter_core.sv =====
// Channel | Dir | Signals                      | Content
// in      | in  | in_tvalid/in_tready/in_tdata | mode, adc_sample
// out     | out | out_tvalid/out_tready/out_tdata | ppm_value, ro_value, status
// cfg     | in  | cfg_we/cfg_addr/cfg_wdata    | register writes, no read-back
//
// One shared 33x33 multiplier and one restoring divider (one quotient bit per cycle)
// work under the sequencer. Early-out status codes go straight to the result.
// in_tready is high only in idle.
// A finished result waits in the output register while the next request is taken.
// rst_n is synchronous: config registers, state and output valid take their reset values, Ro is cleared.
module gas_sensor_ppm_converter_core
  import gsp_pkg::*;
#(
  parameter int ADC_BITS = 10,
  localparam int IN_W = ((1 + ADC_BITS + 7) / 8) * 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [IN_W-1:0]   in_tdata,   // mode, adc_sample
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [71:0]       out_tdata,  // ppm_value[31:0], ro_value[63:32], status[66:64]
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [15:0]       cfg_wdata
);

  localparam logic [ADC_BITS:0] FS = {1'b1, {ADC_BITS{1'b0}}};

  logic [15:0] load_res_r, caf_r, x0_r, y0_r, slope_r;
  logic        gas_sel_r;

  state_t state_r, state_nxt;
  phase_t phase_r, phase_nxt;
  logic                mode_r, mode_nxt;
  logic [ADC_BITS-1:0] s_r, s_nxt;
  logic [31:0]         ro_r, ro_nxt;
  logic signed [65:0]  mul_r, mul_nxt;
  logic [32:0]         rem_r, rem_nxt;
  logic [47:0]         quo_r, quo_nxt;
  logic [31:0]         dvs_r, dvs_nxt;
  logic [5:0]          cnt_r, cnt_nxt;
  logic [31:0]         m_r, m_nxt;
  logic [15:0]         frac_r, frac_nxt;
  logic [4:0]          p_r, p_nxt;
  logic signed [21:0]  lg_r, lg_nxt;
  logic                neg_r, neg_nxt;
  logic signed [31:0]  x_r, x_nxt;
  logic [15:0]         tf_r, tf_nxt;
  logic [31:0]         cand_r, cand_nxt;
  logic [4:0]          bit_r, bit_nxt;
  logic                search_r, search_nxt;
  logic [31:0]         ppm_r, ppm_nxt;
  logic [2:0]          stat_r, stat_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [71:0]         out_data_r, out_data_nxt;

  logic signed [32:0]  mul_a, mul_b;
  logic [32:0]         rem_sh;
  logic                q_bit;
  logic [31:0]         q_sat, rat_v, sq, trial;
  logic [15:0]         frac_fin;
  logic [ADC_BITS:0]   fs_minus;
  logic signed [18:0]  diff;
  logic signed [30:0]  dnum;
  logic [16:0]         slope_mag;
  logic signed [31:0]  qsgn;
  logic signed [53:0]  t_v;
  logic [ADC_BITS-1:0] in_s;
  logic [4:0]          last_bit;

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_res_r <= 16'd2560;
      caf_r      <= 16'd2516;
      x0_r       <= 16'd9421;
      y0_r       <= 16'd721;
      slope_r    <= 16'hF877;
      gas_sel_r  <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_LOAD_RES: load_res_r <= cfg_wdata;
        REG_CAF:      caf_r      <= cfg_wdata;
        REG_X0:       x0_r       <= cfg_wdata;
        REG_Y0:       y0_r       <= cfg_wdata;
        REG_SLOPE:    slope_r    <= cfg_wdata;
        REG_GAS_SEL:  gas_sel_r  <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ro_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ro_r        <= ro_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    phase_r    <= phase_nxt;
    mode_r     <= mode_nxt;
    s_r        <= s_nxt;
    mul_r      <= mul_nxt;
    rem_r      <= rem_nxt;
    quo_r      <= quo_nxt;
    dvs_r      <= dvs_nxt;
    cnt_r      <= cnt_nxt;
    m_r        <= m_nxt;
    frac_r     <= frac_nxt;
    p_r        <= p_nxt;
    lg_r       <= lg_nxt;
    neg_r      <= neg_nxt;
    x_r        <= x_nxt;
    tf_r       <= tf_nxt;
    cand_r     <= cand_nxt;
    bit_r      <= bit_nxt;
    search_r   <= search_nxt;
    ppm_r      <= ppm_nxt;
    stat_r     <= stat_nxt;
    out_data_r <= out_data_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    mode_nxt      = mode_r;
    s_nxt         = s_r;
    ro_nxt        = ro_r;
    rem_nxt       = rem_r;
    quo_nxt       = quo_r;
    dvs_nxt       = dvs_r;
    cnt_nxt       = cnt_r;
    m_nxt         = m_r;
    frac_nxt      = frac_r;
    p_nxt         = p_r;
    lg_nxt        = lg_r;
    neg_nxt       = neg_r;
    x_nxt         = x_r;
    tf_nxt        = tf_r;
    cand_nxt      = cand_r;
    bit_nxt       = bit_r;
    search_nxt    = search_r;
    ppm_nxt       = ppm_r;
    stat_nxt      = stat_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;

    in_s      = in_tdata[ADC_BITS:1];
    fs_minus  = FS - {1'b0, s_r};
    rem_sh    = {rem_r[31:0], quo_r[47]};
    q_bit     = (rem_sh >= {1'b0, dvs_r});
    q_sat     = (|quo_r[47:32]) ? 32'hFFFF_FFFF : quo_r[31:0];
    rat_v     = (q_sat == 32'd0) ? 32'd1 : q_sat;
    sq        = mul_r[61:30];
    frac_fin  = {frac_r[14:0], sq[31]};
    trial     = cand_r | (32'd1 << bit_r);
    last_bit  = 5'd31 - p_r;
    diff      = $signed({mul_r[37], mul_r[37:20]}) - $signed({{3{y0_r[15]}}, y0_r});
    dnum      = {diff[18:0], 12'd0};
    slope_mag = slope_r[15] ? (17'd0 - {1'b1, slope_r}) : {1'b0, slope_r};
    qsgn      = neg_r ? (32'sd0 - $signed(quo_r[31:0])) : $signed(quo_r[31:0]);
    t_v       = mul_r[65:12];

    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      ST_RS_MUL: begin
        mul_a = $signed({{(32 - ADC_BITS){1'b0}}, fs_minus});
        mul_b = $signed({17'd0, load_res_r});
      end
      ST_SQ_MUL: begin
        mul_a = $signed({2'b00, m_r[30:0]});
        mul_b = $signed({2'b00, m_r[30:0]});
      end
      ST_L10_MUL: begin
        mul_a = $signed({{11{lg_r[21]}}, lg_r});
        mul_b = $signed(LOG10_2_Q16);
      end
      ST_T_MUL: begin
        mul_a = $signed({x_r[31], x_r});
        mul_b = $signed(LOG2_10_Q16);
      end
      default: ;
    endcase
    mul_nxt = mul_a * mul_b;

    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          mode_nxt = in_tdata[0];
          s_nxt    = in_s;
          ppm_nxt  = '0;
          stat_nxt = STAT_OK;
          priority if (in_s == '0) begin
            stat_nxt  = STAT_ZERO;
            state_nxt = ST_DONE;
          end else if (!in_tdata[0] && ro_r == '0) begin
            stat_nxt  = STAT_NOCAL;
            state_nxt = ST_DONE;
          end else if (!in_tdata[0] && gas_sel_r) begin
            stat_nxt  = STAT_UNSEL;
            state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_RS_MUL;
          end
        end
      end
      ST_RS_MUL: state_nxt = ST_RS_LD;
      ST_RS_LD: begin
        quo_nxt   = {7'd0, mul_r[32:0], 8'd0};
        dvs_nxt   = {{(32 - ADC_BITS){1'b0}}, s_r};
        rem_nxt   = '0;
        cnt_nxt   = '0;
        phase_nxt = PH_RS;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        rem_nxt = q_bit ? (rem_sh - {1'b0, dvs_r}) : rem_sh;
        quo_nxt = {quo_r[46:0], q_bit};
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'(DIV_STEPS - 1)) state_nxt = ST_DIV_END;
      end
      ST_DIV_END: begin
        rem_nxt = '0;
        cnt_nxt = '0;
        unique case (phase_r)
          PH_RS: begin
            state_nxt = ST_DIV;
            if (mode_r) begin
              quo_nxt   = {8'd0, q_sat, 8'd0};
              dvs_nxt   = (caf_r == 16'd0) ? 32'd1 : {16'd0, caf_r};
              phase_nxt = PH_RO;
            end else begin
              quo_nxt   = {q_sat, 16'd0};
              dvs_nxt   = ro_r;
              phase_nxt = PH_RAT;
            end
          end
          PH_RO: begin
            ro_nxt    = q_sat;
            state_nxt = ST_DONE;
          end
          PH_RAT: begin
            m_nxt     = rat_v;
            p_nxt     = 5'd31;
            state_nxt = ST_NORM;
          end
          PH_X: begin
            x_nxt     = qsgn + $signed({{16{x0_r[15]}}, x0_r});
            state_nxt = ST_T_MUL;
          end
          default: ;
        endcase
      end
      // shift up to the leading one, then drop to Q2.30
      ST_NORM: begin
        if (m_r[31]) begin
          m_nxt      = {1'b0, m_r[31:1]};
          frac_nxt   = '0;
          cnt_nxt    = '0;
          search_nxt = 1'b0;
          state_nxt  = ST_SQ_MUL;
        end else begin
          m_nxt = {m_r[30:0], 1'b0};
          p_nxt = p_r - 5'd1;
        end
      end
      ST_SQ_MUL: state_nxt = ST_SQ_UPD;
      ST_SQ_UPD: begin
        m_nxt    = sq[31] ? {1'b0, sq[31:1]} : sq;
        frac_nxt = frac_fin;
        cnt_nxt  = cnt_r + 6'd1;
        if (cnt_r == 6'(SQ_STEPS - 1)) begin
          if (!search_r) begin
            lg_nxt    = {6'({1'b0, p_r}) - 6'd16, frac_fin};
            state_nxt = ST_L10_MUL;
          end else begin
            if (frac_fin <= tf_r) cand_nxt = trial;
            if (bit_r == last_bit) begin
              ppm_nxt   = ((frac_fin <= tf_r) ? trial : cand_r) >> last_bit;
              state_nxt = ST_DONE;
            end else begin
              bit_nxt   = bit_r - 5'd1;
              state_nxt = ST_TRY;
            end
          end
        end else begin
          state_nxt = ST_SQ_MUL;
        end
      end
      ST_L10_MUL: state_nxt = ST_L10;
      ST_L10: begin
        if (slope_r == 16'd0) begin
          ppm_nxt   = 32'hFFFF_FFFF;
          stat_nxt  = STAT_SAT;
          state_nxt = ST_DONE;
        end else begin
          neg_nxt   = dnum[30] ^ slope_r[15];
          quo_nxt   = {17'd0, dnum[30] ? (31'd0 - dnum) : dnum};
          dvs_nxt   = {15'd0, slope_mag};
          rem_nxt   = '0;
          cnt_nxt   = '0;
          phase_nxt = PH_X;
          state_nxt = ST_DIV;
        end
      end
      ST_T_MUL: state_nxt = ST_T;
      ST_T: begin
        priority if (!t_v[53] && (|t_v[52:21])) begin
          ppm_nxt   = 32'hFFFF_FFFF;
          stat_nxt  = STAT_SAT;
          state_nxt = ST_DONE;
        end else if (t_v[53]) begin
          state_nxt = ST_DONE;
        end else if (t_v[20:16] == 5'd0) begin
          ppm_nxt   = 32'd1;
          state_nxt = ST_DONE;
        end else begin
          p_nxt     = t_v[20:16];
          tf_nxt    = t_v[15:0];
          cand_nxt  = 32'h8000_0000;
          bit_nxt   = 5'd30;
          state_nxt = ST_TRY;
        end
      end
      // try the next ppm bit, held left-aligned in cand
      ST_TRY: begin
        m_nxt      = {1'b0, trial[31:1]};
        frac_nxt   = '0;
        cnt_nxt    = '0;
        search_nxt = 1'b1;
        state_nxt  = ST_SQ_MUL;
      end
      ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {5'd0, stat_r, ro_r, ppm_r};
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule
